[design/skf_pkg.sv]
package skf_pkg;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL_X,
        ST_MUL_P,
        ST_FIN
    } skf_state_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MEAS_NOISE = 2'd0,
        REG_PROC_NOISE = 2'd1,
        REG_START_EST  = 2'd2,
        REG_START_ERR  = 2'd3
    } skf_reg_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } skf_div_stat_t;

    localparam logic [31:0] RST_MEAS_NOISE = 32'd65536;
    localparam logic [31:0] RST_PROC_NOISE = 32'd655;
    localparam logic [31:0] RST_START_EST  = 32'd0;
    localparam logic [31:0] RST_START_ERR  = 32'd65536;

    localparam int DATA_W = 32;
    localparam int OUT_W  = 88;
    localparam int GAIN_W = 17;

endpackage

[design/skf_div.sv]
module skf_div #(
    parameter int GAIN_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              num,
    input  logic [32:0]              den,
    output logic [GAIN_BITS:0]       quot,
    output skf_pkg::skf_div_stat_t   stat
);

    // restoring division of num * 2^GAIN_BITS by den, num <= den
    localparam int CW = $clog2(GAIN_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic                first_reg;
    logic [CW-1:0]       cnt_reg;
    logic [32:0]         rem_reg;
    logic [32:0]         rem_next;
    logic [32:0]         den_reg;
    logic                zero_reg;
    logic [GAIN_BITS:0]  quot_reg;
    logic [33:0]         cand;
    logic [33:0]         diff;
    logic                ge;

    // first step compares without a shift, later steps shift in a zero
    assign cand     = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign diff     = cand - {1'b0, den_reg};
    assign ge       = cand >= {1'b0, den_reg};
    assign rem_next = ge ? diff[32:0] : cand[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= CW'(GAIN_BITS);
            end
            else if (busy_reg)
            begin
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            zero_reg <= (den == '0);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[GAIN_BITS-1:0], ge};
        end
    end

    assign quot      = zero_reg ? '0 : quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/skf_mul.sv]
module skf_mul #(
    parameter int GAIN_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [33:0]          a,
    input  logic [GAIN_BITS:0]          b,
    output logic signed [GAIN_BITS+34:0] prod
);

    localparam int PW = GAIN_BITS + 35;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;

    // signed by unsigned, product fits without the top guard bit
    assign prod_next = PW'(a) * PW'($signed({1'b0, b}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[design/scalar_kalman_filter.sv]
// channel  | dir | signals                          | contents
// ---------+-----+----------------------------------+-----------------------------------
// s        | in  | s_tvalid s_tready s_tdata[31:0]  | sample
// m        | out | m_tvalid m_tready m_tdata[87:0]  | filtered, error_variance, gain_used
// cfg      | in  | cfg_we cfg_index cfg_data        | one register write per cycle
//
// an item goes from transfer in through prep, division, both multiplies and finish to result valid,
// and the next item is taken in the cycle the result appears
// the gain divider retires one quotient bit per cycle and is the longest of those steps
// one registered multiplier is used twice per item, once for the estimate, once for
// the variance
// reset loads the registers and state with their reset values, no clearing pass
// a waiting result holds the sequencer in its last state; s_tready is low while busy
module scalar_kalman_filter #(
    parameter int GAIN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,     // [31:0] filtered, [63:32] error_variance,
                                     // [80:64] gain_used, [87:81] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int PW = GAIN_BITS + 35;
    localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

    skf_pkg::skf_state_t state_reg;
    skf_pkg::skf_state_t state_next;

    // configuration and filter state
    logic [31:0]        r_reg;
    logic [31:0]        q_reg;
    logic [31:0]        est_reg;
    logic [31:0]        err_reg;

    // per item working registers
    logic [31:0]        z_reg;
    logic [31:0]        p1_reg;
    logic [GAIN_BITS:0] k_reg;

    // output register
    logic               m_valid_reg;
    logic [31:0]        filt_reg;
    logic [31:0]        var_reg;
    logic [16:0]        gain_reg;

    // sequencer outputs
    logic               div_start;
    logic               mul_en;
    logic               mul_sel_x;
    logic               est_load;
    logic               out_load;
    logic               out_free;

    logic [32:0]        p1_sum;
    logic [31:0]        p1_sat;
    logic [32:0]        den;
    logic [32:0]        innov;
    logic signed [33:0] mul_a;
    logic [GAIN_BITS:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_shr;
    logic [34:0]        x_sum;
    logic [31:0]        x_sat;
    logic [31:0]        p2;
    logic [GAIN_BITS:0] div_quot;
    skf_pkg::skf_div_stat_t div_stat;

    // predicted variance, saturated to 32 bits
    assign p1_sum = {1'b0, err_reg} + {1'b0, q_reg};
    assign p1_sat = p1_sum[32] ? 32'hFFFF_FFFF : p1_sum[31:0];

    // innovation denominator, exact in 33 bits
    assign den = {1'b0, p1_reg} + {1'b0, r_reg};

    assign innov = {z_reg[31], z_reg} - {est_reg[31], est_reg};

    // shared multiplier: gain times innovation, then variance times (one - gain)
    assign mul_a = mul_sel_x ? $signed({innov[32], innov}) : $signed({2'b00, p1_reg});
    assign mul_b = mul_sel_x ? k_reg : (GAIN_ONE - k_reg);

    skf_div #(
        .GAIN_BITS (GAIN_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p1_reg),
        .den   (den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    skf_mul #(
        .GAIN_BITS (GAIN_BITS)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // floor division by 2^GAIN_BITS, correction stays within 35 signed bits
    assign prod_shr = prod >>> GAIN_BITS;
    assign x_sum    = {{3{est_reg[31]}}, est_reg} + prod_shr[34:0];

    always_comb
    begin
        if (x_sum[34] && !(&x_sum[33:31]))
        begin
            x_sat = 32'h8000_0000;
        end
        else if (!x_sum[34] && (|x_sum[33:31]))
        begin
            x_sat = 32'h7FFF_FFFF;
        end
        else
        begin
            x_sat = x_sum[31:0];
        end
    end

    // variance times (one - gain) never exceeds the predicted variance
    assign p2 = prod[GAIN_BITS+31:GAIN_BITS];

    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = skf_pkg::ST_PREP;
                end
            end
            skf_pkg::ST_PREP:
            begin
                if (!div_stat.busy)
                begin
                    state_next = skf_pkg::ST_DIV;
                end
            end
            skf_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = skf_pkg::ST_MUL_X;
                end
            end
            skf_pkg::ST_MUL_X:
            begin
                state_next = skf_pkg::ST_MUL_P;
            end
            skf_pkg::ST_MUL_P:
            begin
                state_next = skf_pkg::ST_FIN;
            end
            skf_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = skf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        mul_en    = 1'b0;
        mul_sel_x = 1'b0;
        est_load  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            skf_pkg::ST_PREP:
            begin
                div_start = !div_stat.busy;
            end
            skf_pkg::ST_DIV:
            begin
            end
            skf_pkg::ST_MUL_X:
            begin
                mul_en    = 1'b1;
                mul_sel_x = 1'b1;
            end
            skf_pkg::ST_MUL_P:
            begin
                mul_en   = 1'b1;
                est_load = 1'b1;
            end
            skf_pkg::ST_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration and filter state; user writes must come only while idle, unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= skf_pkg::RST_MEAS_NOISE;
            q_reg   <= skf_pkg::RST_PROC_NOISE;
            est_reg <= skf_pkg::RST_START_EST;
            err_reg <= skf_pkg::RST_START_ERR;
        end
        else if (est_load)
        begin
            est_reg <= x_sat;
        end
        else if (out_load)
        begin
            err_reg <= p2;
        end
        else if (cfg_we)
        begin
            unique case (skf_pkg::skf_reg_t'(cfg_index))
                skf_pkg::REG_MEAS_NOISE: r_reg <= cfg_data;
                skf_pkg::REG_PROC_NOISE: q_reg <= cfg_data;
                skf_pkg::REG_START_EST:  est_reg <= cfg_data;
                skf_pkg::REG_START_ERR:  err_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            z_reg  <= s_tdata;
            p1_reg <= p1_sat;
        end
        if ((state_reg == skf_pkg::ST_DIV) && div_stat.done)
        begin
            k_reg <= div_quot;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            filt_reg <= est_reg;
            var_reg  <= p2;
            gain_reg <= 17'(k_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, gain_reg, var_reg, filt_reg};

endmodule

[design/skf_checker.sv]
module skf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // one item at a time: no transfer in right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    // a fresh result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while the block is busy");

    // padding above the gain stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[87:81] == 7'd0))
        else $error("output padding not zero");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/scalar_kalman_filter_test.sv]
module scalar_kalman_filter_test;

    localparam int GAIN_BITS     = 16;
    localparam longint unsigned GAIN_ONE = 64'd1 << GAIN_BITS;
    // leave some margin before a register write
    localparam int SETTLE_CYCLES = GAIN_BITS + 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 190;
    localparam int HOLD_OFF      = 400;
    localparam int HOLD_AFTER    = 300;

    // one result of the filter
    typedef struct packed {
        logic [31:0] filtered;
        logic [31:0] variance;
        logic [16:0] gain;
    } kf_update_t;

    // directed script: a register write or a sample with an optional typed result
    typedef struct packed {
        logic              is_write;
        skf_pkg::skf_reg_t index;
        logic [31:0]       value;
        logic              typed;
        logic [31:0]       exp_filtered;
        logic [31:0]       exp_variance;
        logic [16:0]       exp_gain;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [31:0] sample
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;      // [31:0] filtered, [63:32] error_variance,
                               // [80:64] gain_used, [87:81] zero
    logic        cfg_we;
    skf_pkg::skf_reg_t cfg_index;
    logic [31:0] cfg_data;

    // filter state and registers as the block should hold them
    longint      est_state;
    logic [31:0] err_state;
    logic [31:0] noise_r;
    logic [31:0] noise_q;

    kf_update_t  expected_updates [$];
    int          mismatches;
    int          results_seen;
    int          src_idle_pct;
    int          dst_idle_pct;
    int          hold_left;
    bit          hold_done;
    int          quiet_cycles;

    script_row_t dir_script [32] = '{
        // reset settings
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h0001_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        // zero denominator, estimate holds
        '{1'b1, skf_pkg::REG_MEAS_NOISE, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_PROC_NOISE, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_ERR,  32'h0000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_EST,  32'h1234_5678, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF,
          1'b1, 32'h1234_5678, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h8000_0000,
          1'b1, 32'h1234_5678, 32'h0, 17'h0},
        // unit gain jumps to the sample, then the variance is zero again
        '{1'b1, skf_pkg::REG_START_ERR,  32'h0001_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h0, 17'h1_0000},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h8000_0000,
          1'b1, 32'h7FFF_FFFF, 32'h0, 17'h0},
        // variance saturates, half gain, full scale innovations both ways
        '{1'b1, skf_pkg::REG_PROC_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_ERR,  32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_EST,  32'h8000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF,
          1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 17'h0_8000},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h8000_0000,
          1'b1, 32'hBFFF_FFFF, 32'h7FFF_FFFF, 17'h0_8000},
        '{1'b1, skf_pkg::REG_START_EST,  32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h8000_0000,
          1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 17'h0_8000},
        // full variance with no noise, gain of exactly one
        '{1'b1, skf_pkg::REG_MEAS_NOISE, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_PROC_NOISE, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_ERR,  32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h8000_0000,
          1'b1, 32'h8000_0000, 32'h0, 17'h1_0000},
        // back to the reset settings
        '{1'b1, skf_pkg::REG_MEAS_NOISE, 32'h0001_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_PROC_NOISE, 32'h0000_028F, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_ERR,  32'h0001_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b1, skf_pkg::REG_START_EST,  32'h0000_0000, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h5555_5555, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0, 17'h0},
        '{1'b0, skf_pkg::REG_MEAS_NOISE, 32'h0000_0001, 1'b0, 32'h0, 32'h0, 17'h0}
    };

    scalar_kalman_filter #(
        .GAIN_BITS (GAIN_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // one filter step: predict, weigh by gain, shrink the variance
    function automatic kf_update_t kalman_update(input logic [31:0] z);
        longint unsigned p1;
        longint unsigned denom;
        longint unsigned k;
        longint unsigned p2;
        longint          gain_s;
        longint          innov;
        longint          x;
        kf_update_t      upd;
        p1 = err_state;
        p1 = p1 + noise_q;
        // variance growth saturates at the top of the 32 bit range
        if (p1 > 64'hFFFF_FFFF)
            p1 = 64'hFFFF_FFFF;
        denom = p1 + noise_r;
        k = (denom == 0) ? 64'd0 : (p1 << GAIN_BITS) / denom;
        if (k > GAIN_ONE)
            k = GAIN_ONE;
        innov = $signed(z);
        innov = innov - est_state;
        gain_s = k;
        // arithmetic shift, rounds toward minus infinity
        x = est_state + ((gain_s * innov) >>> GAIN_BITS);
        if (x > 64'sd2147483647)
            x = 64'sd2147483647;
        if (x < -64'sd2147483648)
            x = -64'sd2147483648;
        p2 = (p1 * (GAIN_ONE - k)) >> GAIN_BITS;
        if (p2 > 64'hFFFF_FFFF)
            p2 = 64'hFFFF_FFFF;
        est_state = x;
        err_state = 32'(p2);
        upd.filtered = 32'(x);
        upd.variance = 32'(p2);
        upd.gain     = 17'(k);
        return upd;
    endfunction

    // sample source: half tracking values near the estimate, the rest noise and extremes
    function automatic logic [31:0] pick_sample();
        int  delta;
        int  sel;
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            delta = int'($urandom_range(2097152)) - 1048576;
            return 32'(est_state + delta);
        end
        else if (sel < 80)
            return $urandom;
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'(est_state);
        endcase
    endfunction

    // offer one sample, with random gaps, and log its result once it is taken
    task automatic send_sample(input logic [31:0] z, input logic typed,
                               input kf_update_t typed_upd);
        kf_update_t upd;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= z;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // transfer at this edge
        upd = kalman_update(z);
        if (typed)
            upd = typed_upd;
        expected_updates.push_back(upd);
    endtask

    // quiet the input and let every result and the sequencer finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input skf_pkg::skf_reg_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            skf_pkg::REG_MEAS_NOISE: noise_r = val;
            skf_pkg::REG_PROC_NOISE: noise_q = val;
            skf_pkg::REG_START_EST:  est_state = $signed(val);
            skf_pkg::REG_START_ERR:  err_state = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result checker, oldest expectation first
    always @(posedge clk)
    begin : check_result
        kf_update_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", m_tdata);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (m_tdata[31:0] !== want.filtered || m_tdata[63:32] !== want.variance ||
                    m_tdata[80:64] !== want.gain || m_tdata[87:81] !== 7'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: filtered %h/%h variance %h/%h gain %h/%h pad %h",
                                 want.filtered, m_tdata[31:0], want.variance, m_tdata[63:32],
                                 want.gain, m_tdata[80:64], m_tdata[87:81]);
                end
            end
        end
    end

    // result sink, with one long hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left = HOLD_OFF;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // watchdog on cycles with no transfer or register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] r;
        logic [31:0] q;
        logic [31:0] x0;
        logic [31:0] p0;
        kf_update_t  typed_upd;
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = skf_pkg::REG_MEAS_NOISE;
        cfg_data     = '0;
        mismatches   = 0;
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        quiet_cycles = 0;
        noise_r      = skf_pkg::RST_MEAS_NOISE;
        noise_q      = skf_pkg::RST_PROC_NOISE;
        est_state    = $signed(skf_pkg::RST_START_EST);
        err_state    = skf_pkg::RST_START_ERR;
        // sender idles more rarely than the receiver at first
        src_idle_pct = 38;
        dst_idle_pct = 69;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        foreach (dir_script[i])
        begin
            if (dir_script[i].is_write)
            begin
                wait_idle();
                write_reg(dir_script[i].index, dir_script[i].value);
            end
            else
            begin
                typed_upd.filtered = dir_script[i].exp_filtered;
                typed_upd.variance = dir_script[i].exp_variance;
                typed_upd.gain     = dir_script[i].exp_gain;
                send_sample(dir_script[i].value, dir_script[i].typed, typed_upd);
            end
        end

        // random phases, each under its own noise settings and starting state
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                src_idle_pct = 69;
                dst_idle_pct = 38;
            end
            else if (ph == 4)
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            case (ph)
                0:
                begin
                    r = skf_pkg::RST_MEAS_NOISE;  q = skf_pkg::RST_PROC_NOISE;
                    x0 = $urandom;                p0 = skf_pkg::RST_START_ERR;
                end
                1:
                begin
                    r = $urandom;        q = $urandom;
                    x0 = $urandom;       p0 = $urandom;
                end
                2:
                begin
                    // gain pinned at one while the variance is nonzero
                    r = 32'h0;           q = $urandom_range(32'h0002_0000);
                    x0 = 32'h8000_0000;  p0 = 32'h0;
                end
                3:
                begin
                    r = 32'hFFFF_FFFF;   q = 32'h0;
                    x0 = 32'h7FFF_FFFF;  p0 = 32'hFFFF_FFFF;
                end
                4:
                begin
                    // variance saturates on every step
                    r = $urandom;        q = 32'hFFFF_FFFF;
                    x0 = $urandom;       p0 = $urandom;
                end
                default:
                begin
                    r = $urandom_range(32'h0010_0000);
                    q = $urandom_range(32'h0000_4000);
                    x0 = 32'h0;          p0 = $urandom;
                end
            endcase
            wait_idle();
            write_reg(skf_pkg::REG_MEAS_NOISE, r);
            write_reg(skf_pkg::REG_PROC_NOISE, q);
            write_reg(skf_pkg::REG_START_EST, x0);
            write_reg(skf_pkg::REG_START_ERR, p0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), 1'b0, '0);
        end

        wait_idle();
        if (mismatches == 0 && expected_updates.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
